FILE: design/mwps_pkg.sv
// Shared types, codes and constants for the motor work/pause sequencer.
// Used by the channel interfaces and by every module of the block.
`default_nettype none

package mwps_pkg;

  // Field widths.
  localparam int unsigned OpW     = 3;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned SpeedW  = 2;
  localparam int unsigned LevelW  = 16;
  localparam int unsigned CfgIdxW = 2;

  // Input operation codes.
  localparam logic [OpW-1:0] OP_TICK        = 3'd0;
  localparam logic [OpW-1:0] OP_START       = 3'd1;
  localparam logic [OpW-1:0] OP_STOP        = 3'd2;
  localparam logic [OpW-1:0] OP_TOGGLE_DIR  = 3'd3;
  localparam logic [OpW-1:0] OP_TOGGLE_SPD  = 3'd4;
  localparam logic [OpW-1:0] OP_NEXT_MODE   = 3'd5;
  localparam logic [OpW-1:0] OP_SET_MODE    = 3'd6;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_DUTY_LEVEL0 = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DUTY_LEVEL1 = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DUTY_LEVEL2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_DUTY_OFF    = 2'd3;

  // Mode numbers.
  localparam logic [ModeW-1:0] MODE_BASE = 2'd0;
  localparam logic [ModeW-1:0] MODE_A    = 2'd1;
  localparam logic [ModeW-1:0] MODE_B    = 2'd2;
  localparam logic [ModeW-1:0] MODE_C    = 2'd3;

  // Speed levels.
  localparam logic [SpeedW-1:0] SPEED_0 = 2'd0;
  localparam logic [SpeedW-1:0] SPEED_1 = 2'd1;
  localparam logic [SpeedW-1:0] SPEED_2 = 2'd2;

  // Timer limits.
  localparam logic [LevelW-1:0] REVERSE_INTERVAL = 16'd60000;
  localparam logic [LevelW-1:0] TIMER_MAX        = 16'hFFFF;

  // Reset values of the duty registers.
  localparam logic [LevelW-1:0] RST_DUTY_LEVEL0 = 16'd85;
  localparam logic [LevelW-1:0] RST_DUTY_LEVEL1 = 16'd70;
  localparam logic [LevelW-1:0] RST_DUTY_LEVEL2 = 16'd100;
  localparam logic [LevelW-1:0] RST_DUTY_OFF    = 16'd0;

  typedef struct packed {
    logic [LevelW-1:0] duty_level0;
    logic [LevelW-1:0] duty_level1;
    logic [LevelW-1:0] duty_level2;
    logic [LevelW-1:0] duty_off;
  } mwps_cfg_t;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [ModeW-1:0] target_mode;
    logic             power_on;
  } mwps_item_t;

  typedef struct packed {
    logic              direction;
    logic [ModeW-1:0]  mode;
    logic [SpeedW-1:0] speed;
    logic              phase;
    logic [LevelW-1:0] phase_timer;
    logic [LevelW-1:0] reverse_timer;
    logic [LevelW-1:0] chan1_hold;
    logic [LevelW-1:0] chan2_hold;
  } mwps_state_t;

  // Work phase length of each mode in ticks.
  function automatic logic [LevelW-1:0] work_ticks(input logic [ModeW-1:0] mode);
    logic [LevelW-1:0] t;
    case (mode)
      MODE_BASE: t = 16'd60000;
      MODE_A:    t = 16'd1500;
      MODE_B:    t = 16'd2000;
      default:   t = 16'd1000;
    endcase
    return t;
  endfunction

  // Pause phase length of each mode in ticks.
  function automatic logic [LevelW-1:0] pause_ticks(input logic [ModeW-1:0] mode);
    logic [LevelW-1:0] t;
    case (mode)
      MODE_BASE: t = 16'd1000;
      default:   t = 16'd500;
    endcase
    return t;
  endfunction

  // Duty value of a speed level; the unused level reads as the top level.
  function automatic logic [LevelW-1:0] level_duty(input mwps_cfg_t cfg,
                                                   input logic [SpeedW-1:0] speed);
    logic [LevelW-1:0] d;
    case (speed)
      SPEED_0: d = cfg.duty_level0;
      SPEED_1: d = cfg.duty_level1;
      default: d = cfg.duty_level2;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: design/mwps_intf.sv
// Valid/ready channel interfaces of the motor work/pause sequencer.
// Depends on mwps_pkg for the field widths.
`default_nettype none

// Input items: one operation per transfer.
interface mwps_item_if;
  import mwps_pkg::*;
  logic             valid;
  logic             ready;
  logic [OpW-1:0]   op;
  logic [ModeW-1:0] target_mode;
  logic             power_on;

  modport source (output valid, output op, output target_mode, output power_on, input ready);
  modport sink   (input valid, input op, input target_mode, input power_on, output ready);
endinterface

// Result items: channel levels and status.
interface mwps_result_if;
  import mwps_pkg::*;
  logic              valid;
  logic              ready;
  logic [LevelW-1:0] chan1_level;
  logic [LevelW-1:0] chan2_level;
  logic              reverse_dir;
  logic [ModeW-1:0]  mode_now;
  logic [SpeedW-1:0] speed_now;
  logic              in_work_phase;

  modport source (output valid, output chan1_level, output chan2_level, output reverse_dir,
                  output mode_now, output speed_now, output in_work_phase, input ready);
  modport sink   (input valid, input chan1_level, input chan2_level, input reverse_dir,
                  input mode_now, input speed_now, input in_work_phase, output ready);
endinterface

// Configuration writes: register index and data.
interface mwps_cfg_if;
  import mwps_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] idx;
  logic [LevelW-1:0]  wdata;

  modport source (output valid, output idx, output wdata, input ready);
  modport sink   (input valid, input idx, input wdata, output ready);
endinterface

`default_nettype wire

FILE: design/mwps_cfg_regs.sv
// Duty level configuration registers of the motor work/pause sequencer.
// Depends on mwps_pkg for the register indexes and reset values.
`default_nettype none

module mwps_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        wr_valid_i,
  input  wire logic [mwps_pkg::CfgIdxW-1:0] wr_idx_i,
  input  wire logic [mwps_pkg::LevelW-1:0]  wr_data_i,
  output      logic                        wr_ready_o,
  output      mwps_pkg::mwps_cfg_t         cfg_o
);
  import mwps_pkg::*;

  mwps_cfg_t cfg_q;

  // Writes are always taken.
  assign wr_ready_o = 1'b1;

  // One register is written per transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duty_level0 <= RST_DUTY_LEVEL0;
      cfg_q.duty_level1 <= RST_DUTY_LEVEL1;
      cfg_q.duty_level2 <= RST_DUTY_LEVEL2;
      cfg_q.duty_off    <= RST_DUTY_OFF;
    end else if (wr_valid_i) begin
      unique case (wr_idx_i)
        CFG_DUTY_LEVEL0: cfg_q.duty_level0 <= wr_data_i;
        CFG_DUTY_LEVEL1: cfg_q.duty_level1 <= wr_data_i;
        CFG_DUTY_LEVEL2: cfg_q.duty_level2 <= wr_data_i;
        CFG_DUTY_OFF:    cfg_q.duty_off    <= wr_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: design/mwps_step.sv
// Next-state logic of the motor work/pause sequencer for one input item.
// Depends on mwps_pkg for codes, mode tables and the duty selection.
`default_nettype none

module mwps_step (
  input  wire mwps_pkg::mwps_state_t state_i,
  input  wire mwps_pkg::mwps_item_t  item_i,
  input  wire mwps_pkg::mwps_cfg_t   cfg_i,
  output      mwps_pkg::mwps_state_t state_o
);
  import mwps_pkg::*;

  always_comb begin
    mwps_state_t       s;
    logic              interval;
    logic [LevelW-1:0] duty;

    s        = state_i;
    duty     = '0;
    interval = (state_i.mode == MODE_BASE) || (state_i.mode == MODE_A);

    unique case (item_i.op)
      OP_TICK: begin
        if (item_i.power_on) begin
          // Reversal timer of the interval modes.
          if (interval) begin
            if (s.reverse_timer != TIMER_MAX) begin
              s.reverse_timer = s.reverse_timer + 16'd1;
            end else begin
              s.reverse_timer = '0;
            end
          end
          // Work and pause phase sequencing.
          if (s.phase) begin
            if (s.phase_timer >= work_ticks(s.mode)) begin
              s.chan1_hold  = cfg_i.duty_off;
              s.chan2_hold  = cfg_i.duty_off;
              s.phase       = 1'b0;
              s.phase_timer = '0;
              if (s.mode == MODE_B) begin
                s.direction = ~s.direction;
              end
            end else if (s.phase_timer != TIMER_MAX) begin
              s.phase_timer = s.phase_timer + 16'd1;
            end
          end else begin
            if (s.phase_timer >= pause_ticks(s.mode)) begin
              duty          = level_duty(cfg_i, s.speed);
              s.chan1_hold  = s.direction ? cfg_i.duty_off : duty;
              s.chan2_hold  = s.direction ? duty : cfg_i.duty_off;
              s.phase       = 1'b1;
              s.phase_timer = '0;
            end else if (s.phase_timer != TIMER_MAX) begin
              s.phase_timer = s.phase_timer + 16'd1;
            end
          end
          // Interval reversal flips direction and restarts the drive.
          if (interval && (s.reverse_timer >= REVERSE_INTERVAL)) begin
            s.direction     = ~s.direction;
            s.reverse_timer = '0;
            duty            = level_duty(cfg_i, s.speed);
            s.chan1_hold    = s.direction ? cfg_i.duty_off : duty;
            s.chan2_hold    = s.direction ? duty : cfg_i.duty_off;
          end
        end
      end
      OP_START: begin
        duty         = level_duty(cfg_i, s.speed);
        s.chan1_hold = s.direction ? cfg_i.duty_off : duty;
        s.chan2_hold = s.direction ? duty : cfg_i.duty_off;
      end
      OP_STOP: begin
        s.chan1_hold = cfg_i.duty_off;
        s.chan2_hold = cfg_i.duty_off;
      end
      OP_TOGGLE_DIR: begin
        s.chan1_hold = cfg_i.duty_off;
        s.chan2_hold = cfg_i.duty_off;
        s.direction  = ~s.direction;
      end
      OP_TOGGLE_SPD: begin
        s.speed      = (s.speed >= SPEED_2) ? SPEED_0 : s.speed + 2'd1;
        duty         = level_duty(cfg_i, s.speed);
        s.chan1_hold = s.direction ? cfg_i.duty_off : duty;
        s.chan2_hold = s.direction ? duty : cfg_i.duty_off;
      end
      OP_NEXT_MODE: begin
        s.chan1_hold    = cfg_i.duty_off;
        s.chan2_hold    = cfg_i.duty_off;
        s.mode          = s.mode + 2'd1;
        s.phase_timer   = '0;
        s.reverse_timer = '0;
        s.phase         = 1'b0;
      end
      OP_SET_MODE: begin
        s.mode          = item_i.target_mode;
        s.phase_timer   = '0;
        s.reverse_timer = '0;
        s.phase         = 1'b0;
      end
      default: ;
    endcase

    state_o = s;
  end

endmodule

`default_nettype wire

FILE: design/motor_work_pause_sequencer.sv
// Motor work/pause sequencer: one result per input item, one item per cycle while results are taken.
// An item is held in the input register, and its result is registered in the
// state register once the result slot is free.
// Throughput: one item per cycle while the result sink is ready, set by the single state update per item.
// The result register is the state register itself; it is held while stalled.
// Reset: duty registers to 85/70/100/0, forward, mode 0, speed 0, paused, channels off.
`default_nettype none

module motor_work_pause_sequencer (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  mwps_item_if.sink   item_i,
  mwps_result_if.source result_o,
  mwps_cfg_if.sink    cfg_i
);
  import mwps_pkg::*;

  mwps_cfg_t   cfg;
  mwps_item_t  item_q;
  logic        in_valid_q;
  logic        out_valid_q;
  mwps_state_t state_q;
  mwps_state_t state_d;
  logic        advance;
  logic        in_ready;

  // Duty registers.
  mwps_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_idx_i   (cfg_i.idx),
    .wr_data_i  (cfg_i.wdata),
    .wr_ready_o (cfg_i.ready),
    .cfg_o      (cfg)
  );

  // The held item moves into the state when the result slot is free.
  assign advance  = in_valid_q && (!out_valid_q || result_o.ready);
  assign in_ready = !in_valid_q || advance;
  assign item_i.ready = in_ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && item_i.valid) begin
      item_q.op          <= item_i.op;
      item_q.target_mode <= item_i.target_mode;
      item_q.power_on    <= item_i.power_on;
    end
  end

  // Next state for the held item.
  mwps_step u_step (
    .state_i (state_q),
    .item_i  (item_q),
    .cfg_i   (cfg),
    .state_o (state_d)
  );

  // State and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q           <= 1'b0;
      state_q.direction     <= 1'b0;
      state_q.mode          <= MODE_BASE;
      state_q.speed         <= SPEED_0;
      state_q.phase         <= 1'b0;
      state_q.phase_timer   <= '0;
      state_q.reverse_timer <= '0;
      state_q.chan1_hold    <= RST_DUTY_OFF;
      state_q.chan2_hold    <= RST_DUTY_OFF;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result fields come straight from the state.
  assign result_o.valid         = out_valid_q;
  assign result_o.chan1_level   = state_q.chan1_hold;
  assign result_o.chan2_level   = state_q.chan2_hold;
  assign result_o.reverse_dir   = state_q.direction;
  assign result_o.mode_now      = state_q.mode;
  assign result_o.speed_now     = state_q.speed;
  assign result_o.in_work_phase = state_q.phase;

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for motor_work_pause_sequencer: directed, random and long tick runs.
// Depends on mwps_pkg, the mwps channel interfaces and the sequencer RTL.

module tb;
  import mwps_pkg::*;

  // Op code that the block must treat as a no-op.
  localparam logic [OpW-1:0] OP_UNUSED = 3'd7;
  // Cycles without any transfer before the run is declared hung.
  localparam int STALL_LIMIT = 4000;

  // One status transfer as seen on the result channel.
  typedef struct packed {
    logic [LevelW-1:0] chan1;
    logic [LevelW-1:0] chan2;
    logic              reverse_dir;
    logic [ModeW-1:0]  mode;
    logic [SpeedW-1:0] speed;
    logic              work;
  } status_t;

  // Tracks the sequencer state, predicts each status transfer and checks it.
  class hbridge_scoreboard;
    mwps_state_t st;
    mwps_cfg_t   duty;
    status_t     expected_status[$];
    int failures;
    int items_noted;
    int results_checked;
    int duty_writes;
    int phase_changes;
    int interval_reversals;

    function new();
      duty.duty_level0 = RST_DUTY_LEVEL0;
      duty.duty_level1 = RST_DUTY_LEVEL1;
      duty.duty_level2 = RST_DUTY_LEVEL2;
      duty.duty_off    = RST_DUTY_OFF;
      st = '0;
      st.mode = MODE_BASE;
      st.speed = SPEED_0;
      st.chan1_hold = RST_DUTY_OFF;
      st.chan2_hold = RST_DUTY_OFF;
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    function void write_duty(input logic [CfgIdxW-1:0] idx, input logic [LevelW-1:0] value);
      duty_writes++;
      case (idx)
        CFG_DUTY_LEVEL0: duty.duty_level0 = value;
        CFG_DUTY_LEVEL1: duty.duty_level1 = value;
        CFG_DUTY_LEVEL2: duty.duty_level2 = value;
        default:         duty.duty_off = value;
      endcase
    endfunction

    // Compare value of the current speed level; the spare level acts as the top one.
    function logic [LevelW-1:0] speed_duty();
      case (st.speed)
        SPEED_0: return duty.duty_level0;
        SPEED_1: return duty.duty_level1;
        default: return duty.duty_level2;
      endcase
    endfunction

    function int unsigned work_len(input logic [ModeW-1:0] m);
      case (m)
        MODE_BASE: return 60000;
        MODE_A:    return 1500;
        MODE_B:    return 2000;
        default:   return 1000;
      endcase
    endfunction

    function int unsigned rest_len(input logic [ModeW-1:0] m);
      return (m == MODE_BASE) ? 1000 : 500;
    endfunction

    function void drive();
      if (!st.direction) begin
        st.chan1_hold = speed_duty();
        st.chan2_hold = duty.duty_off;
      end else begin
        st.chan1_hold = duty.duty_off;
        st.chan2_hold = speed_duty();
      end
    endfunction

    function void halt();
      st.chan1_hold = duty.duty_off;
      st.chan2_hold = duty.duty_off;
    endfunction

    function void flip();
      halt();
      st.direction = ~st.direction;
    endfunction

    function void enter_mode(input logic [ModeW-1:0] m);
      st.mode = m;
      st.phase_timer = '0;
      st.reverse_timer = '0;
      st.phase = 1'b0;
    endfunction

    // One millisecond tick: reversal timer, phase timer, then the reversal restart.
    function void advance_tick();
      logic interval;
      interval = (st.mode == MODE_BASE) || (st.mode == MODE_A);
      if (interval) begin
        st.reverse_timer = (st.reverse_timer < TIMER_MAX) ? st.reverse_timer + 1'b1 : '0;
      end
      if (st.phase) begin
        if (st.phase_timer >= work_len(st.mode)) begin
          halt();
          st.phase = 1'b0;
          st.phase_timer = '0;
          phase_changes++;
          if (st.mode == MODE_B) flip();
        end else if (st.phase_timer < TIMER_MAX) begin
          st.phase_timer = st.phase_timer + 1'b1;
        end
      end else begin
        if (st.phase_timer >= rest_len(st.mode)) begin
          drive();
          st.phase = 1'b1;
          st.phase_timer = '0;
          phase_changes++;
        end else if (st.phase_timer < TIMER_MAX) begin
          st.phase_timer = st.phase_timer + 1'b1;
        end
      end
      if (interval && st.reverse_timer >= REVERSE_INTERVAL) begin
        flip();
        st.reverse_timer = '0;
        drive();
        interval_reversals++;
      end
    endfunction

    // Apply one accepted operation and queue the status it must produce.
    function void note_item(input logic [OpW-1:0] op, input logic [ModeW-1:0] target,
                            input logic sys_on);
      items_noted++;
      case (op)
        OP_TICK:       if (sys_on) advance_tick();
        OP_START:      drive();
        OP_STOP:       halt();
        OP_TOGGLE_DIR: flip();
        OP_TOGGLE_SPD: begin
          st.speed = (st.speed >= SPEED_2) ? SPEED_0 : st.speed + 1'b1;
          drive();
        end
        OP_NEXT_MODE: begin
          halt();
          enter_mode(st.mode + 1'b1);
        end
        OP_SET_MODE:   enter_mode(target);
        default: ;
      endcase
      expected_status.push_back('{chan1: st.chan1_hold, chan2: st.chan2_hold,
                                  reverse_dir: st.direction, mode: st.mode,
                                  speed: st.speed, work: st.phase});
    endfunction

    function void compare_field(input string name, input logic [LevelW-1:0] want,
                                input logic [LevelW-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_status(input status_t got);
      status_t want;
      if (expected_status.size() == 0) begin
        $error("status transfer arrived with nothing pending");
        failures++;
        return;
      end
      want = expected_status.pop_front();
      results_checked++;
      compare_field("chan1_level", want.chan1, got.chan1);
      compare_field("chan2_level", want.chan2, got.chan2);
      compare_field("reverse_dir", want.reverse_dir, got.reverse_dir);
      compare_field("mode_now", want.mode, got.mode);
      compare_field("speed_now", want.speed, got.speed);
      compare_field("in_work_phase", want.work, got.work);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   src_idle_pct;
  int   sink_idle_pct;
  int   idle_cycles;

  hbridge_scoreboard sb = new();

  mwps_item_if   item_bus();
  mwps_result_if result_bus();
  mwps_cfg_if    cfg_bus();

  motor_work_pause_sequencer dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_bus),
    .result_o (result_bus),
    .cfg_i    (cfg_bus)
  );

  // 100 MHz clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // The result sink stalls at random at the current idle rate.
  always @(posedge clk_i) begin
    result_bus.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // Check every status transfer against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      sb.check_status('{chan1: result_bus.chan1_level, chan2: result_bus.chan2_level,
                        reverse_dir: result_bus.reverse_dir, mode: result_bus.mode_now,
                        speed: result_bus.speed_now, work: result_bus.in_work_phase});
    end
  end

  // Watchdog: end the run if no transfer happens on any channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (item_bus.valid && item_bus.ready) ||
        (result_bus.valid && result_bus.ready) || (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one operation, with random idle cycles first, and wait for its transfer.
  task automatic send_item(input logic [OpW-1:0] op, input logic [ModeW-1:0] target,
                           input logic sys_on);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_bus.valid       <= 1'b1;
    item_bus.op          <= op;
    item_bus.target_mode <= target;
    item_bus.power_on    <= sys_on;
    @(posedge clk_i);
    while (!item_bus.ready) @(posedge clk_i);
    sb.note_item(op, target, sys_on);
  endtask

  // Stop offering operations and wait until every status has come back.
  task automatic drain_results();
    item_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [LevelW-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.idx   <= idx;
    cfg_bus.wdata <= value;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    sb.write_duty(idx, value);
  endtask

  task automatic write_duties(input logic [LevelW-1:0] l0, input logic [LevelW-1:0] l1,
                              input logic [LevelW-1:0] l2, input logic [LevelW-1:0] off);
    write_reg(CFG_DUTY_LEVEL0, l0);
    write_reg(CFG_DUTY_LEVEL1, l1);
    write_reg(CFG_DUTY_LEVEL2, l2);
    write_reg(CFG_DUTY_OFF, off);
    cfg_bus.valid <= 1'b0;
  endtask

  // Mixed operations, mostly ticks, with random mode targets and power state.
  task automatic random_items(input int count);
    int roll;
    logic [OpW-1:0] op;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 70)      op = OP_TICK;
      else if (roll < 75) op = OP_START;
      else if (roll < 80) op = OP_STOP;
      else if (roll < 85) op = OP_TOGGLE_DIR;
      else if (roll < 90) op = OP_TOGGLE_SPD;
      else if (roll < 93) op = OP_NEXT_MODE;
      else if (roll < 96) op = OP_SET_MODE;
      else                op = OP_UNUSED;
      send_item(op, ModeW'($urandom_range(0, 3)), $urandom_range(0, 99) < 85);
    end
  endtask

  // Long tick train in one mode so the pause timer runs out and the drive starts.
  // Mode changes are left out; buttons and powered-off ticks are sprinkled in.
  task automatic long_tick_run(input logic [ModeW-1:0] m, input int count);
    int roll;
    logic [OpW-1:0] op;
    send_item(OP_SET_MODE, m, 1'b1);
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 97) begin
        send_item(OP_TICK, ModeW'($urandom_range(0, 3)), 1'b1);
      end else if (roll == 97) begin
        send_item(OP_TICK, ModeW'($urandom_range(0, 3)), 1'b0);
      end else begin
        case ($urandom_range(0, 4))
          0:       op = OP_START;
          1:       op = OP_STOP;
          2:       op = OP_TOGGLE_DIR;
          3:       op = OP_TOGGLE_SPD;
          default: op = OP_UNUSED;
        endcase
        send_item(op, ModeW'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Main sequence: reset, directed checks, random phases, a long tick run.
  initial begin
    rst_ni               = 1'b0;
    src_idle_pct         = 6;
    sink_idle_pct        = 84;
    item_bus.valid       <= 1'b0;
    item_bus.op          <= OP_TICK;
    item_bus.target_mode <= MODE_BASE;
    item_bus.power_on    <= 1'b0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.idx          <= CFG_DUTY_LEVEL0;
    cfg_bus.wdata        <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset state, powered-off tick, every button and mode wrap.
    send_item(OP_UNUSED, MODE_BASE, 1'b0);
    send_item(OP_TICK, MODE_C, 1'b0);
    send_item(OP_START, MODE_BASE, 1'b0);
    send_item(OP_TOGGLE_SPD, MODE_BASE, 1'b0);
    send_item(OP_TOGGLE_SPD, MODE_BASE, 1'b0);
    send_item(OP_TOGGLE_SPD, MODE_BASE, 1'b0);
    send_item(OP_TOGGLE_DIR, MODE_BASE, 1'b0);
    send_item(OP_START, MODE_BASE, 1'b0);
    send_item(OP_STOP, MODE_BASE, 1'b0);
    send_item(OP_NEXT_MODE, MODE_BASE, 1'b0);
    send_item(OP_NEXT_MODE, MODE_BASE, 1'b0);
    send_item(OP_NEXT_MODE, MODE_BASE, 1'b0);
    send_item(OP_NEXT_MODE, MODE_BASE, 1'b0);
    send_item(OP_SET_MODE, MODE_C, 1'b1);
    send_item(OP_SET_MODE, MODE_BASE, 1'b1);
    send_item(OP_TICK, MODE_BASE, 1'b1);
    // Speed change in pause drives the motor at once.
    send_item(OP_TOGGLE_SPD, MODE_B, 1'b1);
    send_item(OP_SET_MODE, MODE_B, 1'b1);
    send_item(OP_SET_MODE, MODE_A, 1'b0);
    send_item(OP_UNUSED, MODE_C, 1'b1);

    // Extreme duty values; held levels only pick them up at the next drive or stop.
    drain_results();
    write_duties(16'hFFFF, 16'h0000, 16'($urandom), 16'hFFFF);
    send_item(OP_TICK, MODE_BASE, 1'b1);
    send_item(OP_START, MODE_BASE, 1'b1);
    send_item(OP_TOGGLE_SPD, MODE_BASE, 1'b1);
    send_item(OP_STOP, MODE_BASE, 1'b1);
    random_items(300);

    // Sender mostly idle, sink mostly ready; one full pause midway.
    drain_results();
    src_idle_pct  = 84;
    sink_idle_pct = 6;
    write_duties(16'($urandom), 16'($urandom), 16'($urandom), 16'h0000);
    random_items(150);
    drain_results();
    random_items(150);

    // No idling from here on.
    drain_results();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    write_duties(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    random_items(300);

    drain_results();
    write_duties(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(0, 255)));
    long_tick_run(MODE_B, 540);

    drain_results();
    $display("Covered %0d operations and %0d status transfers over %0d duty writes.",
             sb.items_noted, sb.results_checked, sb.duty_writes);
    $display("Predicted %0d phase changes and %0d interval reversals.",
             sb.phase_changes, sb.interval_reversals);
    if (sb.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
